// File: rtl/latency_histogram_percentile_defines.svh
`ifndef LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH

// check a property on the block clock, off during reset
`define LHP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property only when a result word is offered
`define LHP_RSP_CHECK(label, prop, msg) \
   `LHP_CHECK(label, rsp_valid |-> (prop), msg)

`endif

// File: rtl/lhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lhp_pkg;

   localparam int LIN_BUCKETS = 16;
   localparam int SUB_PER_OCT = 8;
   localparam int SUB_SHIFT   = 3;
   localparam int CUM_W       = 48;
   localparam int TGT_W       = 39;
   localparam int DIV_STEPS   = 64;
   localparam logic [6:0] PCT_MIN = 7'd1;
   localparam logic [6:0] PCT_MAX = 7'd100;

   typedef enum logic [0:0] {
      REQ_PUSH  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] sample_value;
      logic [6:0]  percent;
   } req_word_type;

   typedef struct packed {
      logic [31:0] min_value;
      logic [31:0] max_value;
      logic [31:0] avg_value;
      logic [31:0] pct_value;
      logic [31:0] sample_count;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } lhp_queue_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_ACC,
      ST_OUT
   } lhp_state_type;

   function automatic logic [4:0] lead_bit(input logic [31:0] v);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 1; i < 32; i++) begin
         if (v[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

   function automatic logic [7:0] bucket_of(input logic [31:0] v, input logic [4:0] top_exp,
                                           input logic [7:0] ovf);
      logic [4:0]  e;
      logic [31:0] sh;
      logic [7:0]  res;
      e  = lead_bit(v);
      sh = v >> (e - 5'd3);
      if (v < 32'(LIN_BUCKETS)) begin
         res = v[7:0];
      end else if (e > top_exp) begin
         res = ovf;
      end else begin
         res = 8'(LIN_BUCKETS) + {e[4:0] - 5'd4, 3'b000} + {5'd0, sh[2:0]};
      end
      return res;
   endfunction

   function automatic logic [32:0] bucket_top(input logic [7:0] idx);
      logic [7:0]  k;
      logic [5:0]  s;
      logic [32:0] res;
      k = idx - 8'(LIN_BUCKETS);
      s = 6'(k[7:3]) + 6'd1;
      if (idx < 8'(LIN_BUCKETS)) begin
         res = 33'(idx);
      end else begin
         res = ((33'd8 + 33'(k[2:0])) << s) + (33'd1 << s) - 33'd1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: rtl/latency_histogram_percentile.sv
// Latency statistics monitor with a log-linear bucket histogram.
// Input channel req_valid/req_ready/req_word: a push word records one sample,
// a query word asks for min, max, average, count and a percentile bound.
// Result channel rsp_valid/rsp_ready/rsp_word: one word per query, none per push.
// A two-word input queue lets the sender keep going while the engine works.
// Push: the engine dispatches, reads the bucket, then increments and writes it.
// Query: dispatch, one-bit-per-cycle division for the average, then the bucket
// walk, a read and an accumulate step for each bucket visited (up to 17+8*OCTAVE_COUNT
// buckets), then a load of the result register.
// Reset: a clearing pass writes every bucket to zero, 17+8*OCTAVE_COUNT buckets
// (145 at the default), during which queued words wait.
// When the receiver stalls, the result register holds its word; the engine
// waits with the next result and the input queue fills, then req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "latency_histogram_percentile_defines.svh"
module latency_histogram_percentile import lhp_pkg::*; #(
   parameter int OCTAVE_COUNT = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   lhp_queue_type queue;
   logic          queue_pop;
   logic          rsp_empty_ok;

   assign rsp_empty_ok = (rsp_word.sample_count != 32'd0)
                         || (rsp_word.pct_value == 32'd0 && rsp_word.avg_value == 32'd0);

   lhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .queue_out (queue),
      .queue_pop (queue_pop)
   );

   lhp_back #(
      .OCTAVE_COUNT (OCTAVE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_in  (queue),
      .queue_pop (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   `LHP_RSP_CHECK(a_pct_capped, rsp_word.pct_value <= rsp_word.max_value, "pct above max")
   `LHP_RSP_CHECK(a_min_le_max, rsp_word.min_value <= rsp_word.max_value, "min above max")
   `LHP_RSP_CHECK(a_avg_le_max, rsp_word.avg_value <= rsp_word.max_value, "avg above max")
   `LHP_RSP_CHECK(a_empty_zero, rsp_empty_ok, "empty stats not zero")

endmodule
`default_nettype wire

// File: rtl/lhp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lhp_front import lhp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_word_type  req_word,
   output lhp_queue_type      queue_out,
   input  wire logic          queue_pop
);

   req_word_type slot_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic         push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = queue_pop && (cnt_ff != 2'd0);

   assign queue_out.valid = (cnt_ff != 2'd0);
   assign queue_out.word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule
`default_nettype wire

// File: rtl/lhp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lhp_back import lhp_pkg::*; #(
   parameter int OCTAVE_COUNT = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lhp_queue_type queue_in,
   output logic               queue_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_word_type       rsp_word
);

   localparam int NUM_BUCKETS = LIN_BUCKETS + SUB_PER_OCT * OCTAVE_COUNT + 1;
   localparam int IDX_W       = $clog2(NUM_BUCKETS);
   localparam logic [IDX_W-1:0] OVF_IDX = IDX_W'(NUM_BUCKETS - 1);
   localparam logic [4:0]       TOP_EXP = 5'(3 + OCTAVE_COUNT);

   logic [31:0] mem [NUM_BUCKETS];
   logic [31:0] rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   logic [31:0]       mem_wdata;

   lhp_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   req_word_type      word_ff, word_in;
   logic [31:0]       min_ff, min_in, max_ff, max_in, count_ff, count_in;
   logic [63:0]       sum_ff, sum_in;
   logic [CUM_W-1:0]  cum_ff, cum_in;
   logic [TGT_W-1:0]  target_ff, target_in;
   logic [31:0]       rem_ff, rem_in;
   logic [63:0]       dq_ff, dq_in;
   logic [5:0]        step_ff, step_in;
   logic [31:0]       pct_ff, pct_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [6:0]        pct_clamp;
   logic [32:0]       rem_sh;
   logic [32:0]       top;
   logic [CUM_W-1:0]  cum_next;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      pct_clamp = word_ff.percent;
      if (pct_clamp < PCT_MIN) begin
         pct_clamp = PCT_MIN;
      end else if (pct_clamp > PCT_MAX) begin
         pct_clamp = PCT_MAX;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      cum_in       = cum_ff;
      target_in    = target_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      step_in      = step_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      queue_pop    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = 32'd0;
      mem_raddr    = idx_ff;
      rem_sh       = {rem_ff, dq_ff[63]};
      top          = bucket_top(8'(idx_ff));
      cum_next     = cum_ff + CUM_W'(rd_data_ff) * CUM_W'(100);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == OVF_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            queue_pop = queue_in.valid;
            if (queue_in.valid) begin
               word_in = queue_in.word;
               if (queue_in.word.req_type == REQ_PUSH) begin
                  idx_in   = IDX_W'(bucket_of(queue_in.word.sample_value, TOP_EXP,
                                              8'(OVF_IDX)));
                  state_in = ST_PUSH_RD;
               end else if (count_ff == 32'd0) begin
                  dq_in    = 64'd0;
                  pct_in   = 32'd0;
                  state_in = ST_OUT;
               end else begin
                  rem_in   = 32'd0;
                  dq_in    = sum_ff;
                  step_in  = 6'd0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_PUSH_RD: begin
            state_in = ST_PUSH_WR;
         end
         ST_PUSH_WR: begin
            mem_we    = (rd_data_ff != 32'hFFFF_FFFF);
            mem_wdata = rd_data_ff + 32'd1;
            if (count_ff == 32'd0 || word_ff.sample_value < min_ff) begin
               min_in = word_ff.sample_value;
            end
            if (word_ff.sample_value > max_ff) begin
               max_in = word_ff.sample_value;
            end
            if (count_ff != 32'hFFFF_FFFF) begin
               sum_in   = sum_ff + 64'(word_ff.sample_value);
               count_in = count_ff + 32'd1;
            end
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            target_in = TGT_W'(count_ff) * TGT_W'(pct_clamp);
            if (rem_sh >= {1'b0, count_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, count_ff});
               dq_in  = {dq_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               dq_in  = {dq_ff[62:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(DIV_STEPS - 1)) begin
               idx_in   = '0;
               cum_in   = '0;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_ACC;
         end
         ST_WALK_ACC: begin
            cum_in = cum_next;
            if (idx_ff == OVF_IDX) begin
               pct_in   = max_ff;
               state_in = ST_OUT;
            end else if (cum_next >= CUM_W'(target_ff)) begin
               pct_in   = (top < 33'(max_ff)) ? top[31:0] : max_ff;
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.min_value    = min_ff;
               rsp_word_in.max_value    = max_ff;
               rsp_word_in.avg_value    = dq_ff[31:0];
               rsp_word_in.pct_value    = pct_ff;
               rsp_word_in.sample_count = count_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         min_ff       <= 32'd0;
         max_ff       <= 32'd0;
         count_ff     <= 32'd0;
         sum_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      cum_ff      <= cum_in;
      target_ff   <= target_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      step_ff     <= step_in;
      pct_ff      <= pct_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule
`default_nettype wire
